// ----- rtl/round_robin_run_queue_core_macros.svh -----
// Assertion macros shared by the run queue RTL
`ifndef ROUND_ROBIN_RUN_QUEUE_CORE_MACROS_SVH
`define ROUND_ROBIN_RUN_QUEUE_CORE_MACROS_SVH

// Checked at every rising clock edge outside reset
`define RRQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies a result in the next
`define RRQ_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/rrq_pkg.sv -----
// Shared types and constants for the round robin run queue
package rrq_pkg;

  localparam int TASK_W    = 4;
  localparam int NUM_TASKS = 1 << TASK_W;
  localparam int COUNT_W   = TASK_W + 1;
  localparam int TIME_W    = 48;
  localparam int SLICE_W   = 16;
  localparam int KIND_W    = 3;

  localparam logic [COUNT_W-1:0] CNT_ONE   = COUNT_W'(1);
  localparam logic [SLICE_W-1:0] SLICE_ONE = SLICE_W'(1);

  typedef enum logic [KIND_W-1:0] {
    K_ENQ   = 3'd0,
    K_DEQ   = 3'd1,
    K_YIELD = 3'd2,
    K_TICK  = 3'd3,
    K_PICK  = 3'd4,
    K_PUT   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_DUP    = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    logic append;
    logic unlink;
    logic move;
  } list_op_t;

  typedef struct packed {
    logic              charge;
    logic              tick;
    logic              pick;
    logic              put;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] now;
  } acct_ctl_t;

endpackage

// ----- rtl/round_robin_run_queue_core.sv -----
// Top level of the round robin run queue with time quantum
//
//  channel  handshake           payload
//  in       start / busy        in_kind, in_task_id, in_now
//  out      out_valid (strobe)  out_picked_task, out_picked_valid, out_resched,
//                               out_queued_count, out_current_runtime, out_status
//  cfg      cfg_wr_en           cfg_wr_data (time slice)
//
// One event is taken every cycle; busy stays low.
// An event lands in the input register; in the following cycle the queue table
// and accounting update and its result strobes.
// Synchronous active-low reset empties the queue and clears all accounting.
// Results cannot be stalled; out_valid is high for exactly one cycle per event.
`include "round_robin_run_queue_core_macros.svh"
module round_robin_run_queue_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rrq_pkg::KIND_W-1:0]    in_kind,
  input  logic [rrq_pkg::TASK_W-1:0]    in_task_id,
  input  logic [rrq_pkg::TIME_W-1:0]    in_now,
  output logic                          out_valid,
  output logic [rrq_pkg::TASK_W-1:0]    out_picked_task,
  output logic                          out_picked_valid,
  output logic                          out_resched,
  output logic [rrq_pkg::COUNT_W-1:0]   out_queued_count,
  output logic [rrq_pkg::TIME_W-1:0]    out_current_runtime,
  output logic [1:0]                    out_status,
  input  logic                          cfg_wr_en,
  input  logic [rrq_pkg::SLICE_W-1:0]   cfg_wr_data
);

  logic                        in_vld_r;
  logic [rrq_pkg::KIND_W-1:0]  kind_r;
  logic [rrq_pkg::TASK_W-1:0]  id_r;
  logic [rrq_pkg::TIME_W-1:0]  now_r;

  logic                        out_valid_r;
  logic [rrq_pkg::TASK_W-1:0]  picked_task_r, picked_task_nxt;
  logic                        picked_valid_r, picked_valid_nxt;
  logic                        resched_r;
  rrq_pkg::status_t            status_r, status_nxt;

  logic is_enq, is_deq, is_yield, is_tick, is_pick, is_put;
  logic [rrq_pkg::TASK_W-1:0]  tgt, head_task, cur_task;
  logic [rrq_pkg::COUNT_W-1:0] queue_count;
  logic                        tgt_inq, cur_valid, expire, nonempty;
  rrq_pkg::list_op_t           op;
  rrq_pkg::acct_ctl_t          ctl;

  assign busy = 1'b0;

  always_comb begin
    is_enq   = in_vld_r && (kind_r == rrq_pkg::K_ENQ);
    is_deq   = in_vld_r && (kind_r == rrq_pkg::K_DEQ);
    is_yield = in_vld_r && (kind_r == rrq_pkg::K_YIELD);
    is_tick  = in_vld_r && (kind_r == rrq_pkg::K_TICK);
    is_pick  = in_vld_r && (kind_r == rrq_pkg::K_PICK);
    is_put   = in_vld_r && (kind_r == rrq_pkg::K_PUT);
    nonempty = (queue_count != '0);
    tgt      = is_yield ? cur_task : id_r;

    op.append = is_enq && !tgt_inq;
    op.unlink = is_deq && tgt_inq;
    op.move   = (is_yield && cur_valid && tgt_inq) || (is_tick && expire && tgt_inq);

    ctl.charge  = is_enq || is_deq || is_tick || is_put;
    ctl.tick    = is_tick;
    ctl.pick    = is_pick && nonempty;
    ctl.put     = is_put;
    ctl.task_id = id_r;
    ctl.now     = now_r;

    status_nxt = rrq_pkg::ST_OK;
    if (is_enq && tgt_inq) begin
      status_nxt = rrq_pkg::ST_DUP;
    end
    if ((is_deq && !tgt_inq) || (is_yield && !(cur_valid && tgt_inq))) begin
      status_nxt = rrq_pkg::ST_ABSENT;
    end
    if (is_pick && !nonempty) begin
      status_nxt = rrq_pkg::ST_EMPTY;
    end
    picked_valid_nxt = is_pick && nonempty;
    picked_task_nxt  = picked_valid_nxt ? head_task : '0;
  end

  rrq_list u_list (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .tgt         (tgt),
    .tgt_inq     (tgt_inq),
    .head_task   (head_task),
    .queue_count (queue_count)
  );

  rrq_acct u_acct (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .head_task   (head_task),
    .cur_task    (cur_task),
    .cur_valid   (cur_valid),
    .expire      (expire),
    .runtime     (out_current_runtime)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_vld_r    <= start;
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kind_r <= in_kind;
      id_r   <= in_task_id;
      now_r  <= in_now;
    end
    picked_task_r  <= picked_task_nxt;
    picked_valid_r <= picked_valid_nxt;
    resched_r      <= expire;
    status_r       <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_picked_task  = picked_task_r;
  assign out_picked_valid = picked_valid_r;
  assign out_resched      = resched_r;
  assign out_queued_count = queue_count;
  assign out_status       = status_r;

  `RRQ_ASSERT(a_strobe_follows_input, out_valid_r |-> $past(in_vld_r), "stray strobe")
  `RRQ_ASSERT_NEXT(a_pick_ok, is_pick && nonempty, picked_valid_r && (status_r == rrq_pkg::ST_OK), "pick lost")
  `RRQ_ASSERT_NEXT(a_pick_sets_current, is_pick && nonempty, cur_valid && (cur_task == $past(head_task)), "current not set")

endmodule

// ----- rtl/rrq_list.sv -----
// Doubly linked run queue table with head, tail, count and membership bits
`include "round_robin_run_queue_core_macros.svh"
module rrq_list (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rrq_pkg::list_op_t            op,
  input  logic [rrq_pkg::TASK_W-1:0]   tgt,
  output logic                         tgt_inq,
  output logic [rrq_pkg::TASK_W-1:0]   head_task,
  output logic [rrq_pkg::COUNT_W-1:0]  queue_count
);

  logic [rrq_pkg::TASK_W-1:0]    next_r [rrq_pkg::NUM_TASKS];
  logic [rrq_pkg::TASK_W-1:0]    prev_r [rrq_pkg::NUM_TASKS];
  logic [rrq_pkg::TASK_W-1:0]    next_nxt [rrq_pkg::NUM_TASKS];
  logic [rrq_pkg::TASK_W-1:0]    prev_nxt [rrq_pkg::NUM_TASKS];
  logic [rrq_pkg::NUM_TASKS-1:0] inq_r, inq_nxt;
  logic [rrq_pkg::TASK_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [rrq_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic [rrq_pkg::TASK_W-1:0]    p, n;

  assign tgt_inq     = inq_r[tgt];
  assign head_task   = head_r;
  assign queue_count = count_r;

  // unlink then append; a move is both, the later write wins
  always_comb begin
    next_nxt  = next_r;
    prev_nxt  = prev_r;
    inq_nxt   = inq_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    p = prev_r[tgt];
    n = next_r[tgt];
    if (op.unlink || op.move) begin
      if (tgt == head_nxt) begin
        head_nxt = n;
      end else begin
        next_nxt[p] = n;
      end
      if (tgt == tail_nxt) begin
        tail_nxt = p;
      end else begin
        prev_nxt[n] = p;
      end
      inq_nxt[tgt] = 1'b0;
      count_nxt = count_nxt - rrq_pkg::CNT_ONE;
    end
    if (op.append || op.move) begin
      if (count_nxt == '0) begin
        head_nxt = tgt;
        prev_nxt[tgt] = tgt;
      end else begin
        next_nxt[tail_nxt] = tgt;
        prev_nxt[tgt] = tail_nxt;
      end
      tail_nxt = tgt;
      next_nxt[tgt] = tgt;
      inq_nxt[tgt] = 1'b1;
      count_nxt = count_nxt + rrq_pkg::CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      inq_r   <= inq_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_r <= next_nxt;
    prev_r <= prev_nxt;
  end

  `RRQ_ASSERT(a_count_matches, int'(count_r) == $countones(inq_r), "count mismatch")
  `RRQ_ASSERT(a_head_queued, (count_r != '0) |-> (inq_r[head_r] && inq_r[tail_r]), "ends lost")
  `RRQ_ASSERT_NEXT(a_move_keeps_count, op.move, $stable(count_r), "move changed count")

endmodule

// ----- rtl/rrq_acct.sv -----
// Current task, runtime charging and time slice countdown
module rrq_acct (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rrq_pkg::SLICE_W-1:0]  cfg_wr_data,
  input  rrq_pkg::acct_ctl_t           ctl,
  input  logic [rrq_pkg::TASK_W-1:0]   head_task,
  output logic [rrq_pkg::TASK_W-1:0]   cur_task,
  output logic                         cur_valid,
  output logic                         expire,
  output logic [rrq_pkg::TIME_W-1:0]   runtime
);

  logic [rrq_pkg::SLICE_W-1:0] time_slice_r;
  logic [rrq_pkg::SLICE_W-1:0] slice_r [rrq_pkg::NUM_TASKS];
  logic [rrq_pkg::TIME_W-1:0]  total_r [rrq_pkg::NUM_TASKS];
  logic [rrq_pkg::TIME_W-1:0]  longest_r [rrq_pkg::NUM_TASKS];
  logic [rrq_pkg::TASK_W-1:0]  cur_r;
  logic                        cur_valid_r;
  logic [rrq_pkg::TIME_W-1:0]  start_r, start_nxt;
  logic [rrq_pkg::TIME_W:0]    diff, sum;
  logic [rrq_pkg::TIME_W-1:0]  elapsed, total_nxt, longest_nxt;
  logic                        do_charge;
  logic [rrq_pkg::SLICE_W-1:0] slice_cur;

  assign cur_task  = cur_r;
  assign cur_valid = cur_valid_r;
  assign runtime   = cur_valid_r ? total_r[cur_r] : '0;
  assign slice_cur = slice_r[ctl.task_id];
  assign expire    = ctl.tick && (time_slice_r != '0) && (slice_cur == '0);

  always_comb begin
    do_charge   = ctl.charge && cur_valid_r;
    diff        = {1'b0, ctl.now} - {1'b0, start_r};
    elapsed     = diff[rrq_pkg::TIME_W] ? '0 : diff[rrq_pkg::TIME_W-1:0];
    sum         = {1'b0, total_r[cur_r]} + {1'b0, elapsed};
    total_nxt   = sum[rrq_pkg::TIME_W] ? '1 : sum[rrq_pkg::TIME_W-1:0];
    longest_nxt = (elapsed > longest_r[cur_r]) ? elapsed : longest_r[cur_r];
    start_nxt   = start_r;
    if (do_charge) begin
      start_nxt = ctl.now;
    end
    if (ctl.put && cur_valid_r && (cur_r == ctl.task_id)) begin
      start_nxt = '0;
    end
    if (ctl.pick) begin
      start_nxt = ctl.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_slice_r <= '0;
      slice_r      <= '{default: '0};
      total_r      <= '{default: '0};
      longest_r    <= '{default: '0};
      cur_r        <= '0;
      cur_valid_r  <= 1'b0;
      start_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        time_slice_r <= cfg_wr_data;
      end
      if (do_charge) begin
        total_r[cur_r]   <= total_nxt;
        longest_r[cur_r] <= longest_nxt;
      end
      if (ctl.tick && (time_slice_r != '0)) begin
        slice_r[ctl.task_id] <= expire ? time_slice_r : slice_cur - rrq_pkg::SLICE_ONE;
      end
      if (ctl.pick) begin
        cur_r       <= head_task;
        cur_valid_r <= 1'b1;
      end
      start_r <= start_nxt;
    end
  end

endmodule
